// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files of the MIDI packetizer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_s, rst_s, cond, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/midipkt_pkg.sv =====
// ---------------------------------------------------------------------------
// midipkt_pkg
// Types and constants of the MIDI byte to USB-MIDI packet converter.
// ---------------------------------------------------------------------------
`default_nettype none

package midipkt_pkg;

  // MIDI status bytes and masks
  localparam logic [7:0] RT_MIN      = 8'hF8;
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] TUNE_REQ    = 8'hF6;
  localparam logic [7:0] SONG_SEL_QF = 8'hF1;
  localparam logic [7:0] SONG_SEL    = 8'hF3;
  localparam logic [7:0] TWO_BYTE_MASK = 8'hE0;
  localparam logic [7:0] TWO_BYTE_CHAN = 8'hC0;
  localparam logic [7:0] NO_STATUS   = 8'h00;

  // Code index numbers
  localparam logic [3:0] CIN_SYS2       = 4'h2;
  localparam logic [3:0] CIN_SYS3       = 4'h3;
  localparam logic [3:0] CIN_SYSEX      = 4'h4;
  localparam logic [3:0] CIN_SYS1       = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
  localparam logic [3:0] CIN_SINGLE     = 4'hF;

  localparam int unsigned MSG_DEPTH = 3;

  // One USB-MIDI event packet, cable zero
  typedef struct packed {
    logic [7:0] third_byte;
    logic [7:0] second_byte;
    logic [7:0] first_byte;
    logic [3:0] code_index;
  } packet_t;

  // Byte held by the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] midi_byte;
  } in_item_t;

endpackage

`default_nettype wire

// ===== rtl/midi_bytes_to_usb_midi_packets.sv =====
// ---------------------------------------------------------------------------
// midi_bytes_to_usb_midi_packets
// Serial MIDI byte stream to USB-MIDI event packets on cable zero.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel: one MIDI byte per transfer on s_tdata[7:0].
//   Master channel: one USB-MIDI event packet per transfer; the code index
//   travels on m_tuser[3:0], the three packet bytes on m_tdata.
//   A byte that completes a message (or any real-time byte) gives one
//   packet; other bytes give none. Unused packet bytes are zero.
// Path: the byte that completes a packet passes the input register, then
//   the output register, before m_tvalid rises.
// Throughput: one byte per cycle while the skid entry is free; the decision
//   between the input register and the output register is combinational.
// Reset: rst clears the message in assembly, the running status, the sysex
//   flag, the input, output and skid registers; nothing is pending afterwards.
// Stall: while m_tready is low the packet holds; one more packet goes to a
//   skid entry, after which s_tready drops until the receiver takes data.
// ---------------------------------------------------------------------------
`default_nettype none

module midi_bytes_to_usb_midi_packets (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] midi_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] first_byte, [15:8] second_byte, [23:16] third_byte
  output logic [3:0]       m_tuser    // [3:0] code_index
);

  midipkt_pkg::in_item_t item;
  midipkt_pkg::packet_t  pkt;
  midipkt_pkg::packet_t  out_pkt;
  logic                  consume;
  logic                  push;
  logic                  up_ready;

  // Input register
  midipkt_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .consume  (consume),
    .item     (item)
  );

  // Message assembly and packet decision
  midipkt_assembler u_assembler (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .out_ready (up_ready),
    .consume   (consume),
    .push      (push),
    .pkt       (pkt)
  );

  // Output register with skid entry
  midipkt_out_skid u_out_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (pkt),
    .up_ready (up_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_pkt    (out_pkt)
  );

  assign m_tdata = {out_pkt.third_byte, out_pkt.second_byte, out_pkt.first_byte};
  assign m_tuser = out_pkt.code_index;

endmodule

`default_nettype wire

// ===== rtl/midipkt_in_stage.sv =====
// ---------------------------------------------------------------------------
// midipkt_in_stage
// Input register: captures one MIDI byte per transfer and holds it until
// the assembler consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module midipkt_in_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,
  input  wire logic                  consume,
  output midipkt_pkg::in_item_t      item
);

  logic       valid;
  logic [7:0] midi_byte;

  // Accept while empty or while the held byte leaves this cycle
  assign s_tready = !valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  // Capture the byte on a transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      midi_byte <= s_tdata;
    end
  end

  assign item.valid     = valid;
  assign item.midi_byte = midi_byte;

endmodule

`default_nettype wire

// ===== rtl/midipkt_assembler.sv =====
// ---------------------------------------------------------------------------
// midipkt_assembler
// Message assembly: running status, sysex chunking and packet decision for
// one MIDI byte per cycle while the output side has room.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module midipkt_assembler (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire midipkt_pkg::in_item_t item,
  input  wire logic                  out_ready,
  output logic                       consume,
  output logic                       push,
  output midipkt_pkg::packet_t       pkt
);

  logic [7:0] msg_bytes [midipkt_pkg::MSG_DEPTH];
  logic [1:0] byte_count;
  logic [7:0] running_status;
  logic       in_sysex;

  logic [7:0] msg_bytes_next [midipkt_pkg::MSG_DEPTH];
  logic [1:0] byte_count_next;
  logic [7:0] running_status_next;
  logic       in_sysex_next;
  logic       emit;

  logic [7:0] b;

  assign b       = item.midi_byte;
  assign consume = item.valid && out_ready;
  assign push    = consume && emit;

  // Decide the next state and the packet for the held byte
  always_comb begin
    logic [7:0] work [midipkt_pkg::MSG_DEPTH];
    logic [1:0] wcnt;
    logic [7:0] status;
    logic       len_two;

    msg_bytes_next      = msg_bytes;
    byte_count_next     = byte_count;
    running_status_next = running_status;
    in_sysex_next       = in_sysex;
    emit                = 1'b0;
    pkt                 = '0;
    work                = msg_bytes;
    wcnt                = byte_count;
    status              = msg_bytes[0];
    len_two             = 1'b0;

    if (b >= midipkt_pkg::RT_MIN) begin
      // Real-time byte: pass through, leave assembly alone
      emit            = 1'b1;
      pkt.code_index  = midipkt_pkg::CIN_SINGLE;
      pkt.first_byte  = b;
    end else if (b == midipkt_pkg::SYSEX_END && in_sysex) begin
      // Close the sysex with the remaining bytes
      work[byte_count] = b;
      emit             = 1'b1;
      pkt.code_index   = midipkt_pkg::CIN_SYSEX_END1 + {2'b00, byte_count};
      pkt.first_byte   = work[0];
      pkt.second_byte  = work[1];
      pkt.third_byte   = work[2];
      msg_bytes_next   = '{default: '0};
      byte_count_next  = '0;
      in_sysex_next    = 1'b0;
    end else if (b[7]) begin
      // Status byte: start a new message
      msg_bytes_next      = '{default: '0};
      msg_bytes_next[0]   = b;
      byte_count_next     = 2'd1;
      in_sysex_next       = (b == midipkt_pkg::SYSEX_START);
      running_status_next = (b < midipkt_pkg::SYSEX_START) ? b : midipkt_pkg::NO_STATUS;
      if (b == midipkt_pkg::TUNE_REQ) begin
        emit            = 1'b1;
        pkt.code_index  = midipkt_pkg::CIN_SYS1;
        pkt.first_byte  = b;
        msg_bytes_next  = '{default: '0};
        byte_count_next = '0;
      end
    end else if (in_sysex) begin
      // Sysex data: send every full chunk of three
      work[byte_count] = b;
      if (byte_count == 2'd2) begin
        emit            = 1'b1;
        pkt.code_index  = midipkt_pkg::CIN_SYSEX;
        pkt.first_byte  = work[0];
        pkt.second_byte = work[1];
        pkt.third_byte  = work[2];
        msg_bytes_next  = '{default: '0};
        byte_count_next = '0;
      end else begin
        msg_bytes_next  = work;
        byte_count_next = byte_count + 2'd1;
      end
    end else if (byte_count != 2'd0 || running_status != midipkt_pkg::NO_STATUS) begin
      // Channel or system common data, with running status when no message is open
      if (byte_count == 2'd0) begin
        work[0] = running_status;
        wcnt    = 2'd1;
      end
      work[wcnt] = b;
      status     = work[0];
      len_two    = ((status & midipkt_pkg::TWO_BYTE_MASK) == midipkt_pkg::TWO_BYTE_CHAN) ||
                   (status == midipkt_pkg::SONG_SEL_QF) || (status == midipkt_pkg::SONG_SEL);
      if (len_two || wcnt == 2'd2) begin
        emit            = 1'b1;
        if (status < midipkt_pkg::SYSEX_START) begin
          pkt.code_index = status[7:4];
        end else begin
          pkt.code_index = len_two ? midipkt_pkg::CIN_SYS2 : midipkt_pkg::CIN_SYS3;
        end
        pkt.first_byte  = work[0];
        pkt.second_byte = work[1];
        pkt.third_byte  = work[2];
        msg_bytes_next  = '{default: '0};
        byte_count_next = '0;
      end else begin
        msg_bytes_next  = work;
        byte_count_next = wcnt + 2'd1;
      end
    end
    // Otherwise drop a data byte that has no status
  end

  // Advance the assembly state when the byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_bytes      <= '{default: '0};
      byte_count     <= '0;
      running_status <= midipkt_pkg::NO_STATUS;
      in_sysex       <= 1'b0;
    end else if (consume) begin
      msg_bytes      <= msg_bytes_next;
      byte_count     <= byte_count_next;
      running_status <= running_status_next;
      in_sysex       <= in_sysex_next;
    end
  end

  `ASSERT_ALWAYS(a_count_below_three, clk, rst, byte_count != 2'd3, "byte count reached three")
  `ASSERT_IMPLIES(a_sysex_no_running, clk, rst, in_sysex, running_status == midipkt_pkg::NO_STATUS, "running status kept during sysex")
  `ASSERT_IMPLIES(a_empty_msg_zero, clk, rst, byte_count == 2'd0, msg_bytes[0] == 8'h00 && msg_bytes[1] == 8'h00 && msg_bytes[2] == 8'h00, "stale bytes in empty message")

endmodule

`default_nettype wire

// ===== rtl/midipkt_out_skid.sv =====
// ---------------------------------------------------------------------------
// midipkt_out_skid
// Output register with a skid entry, so a packet can be taken in every
// cycle while the skid entry is empty, and none is lost while the receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module midipkt_out_skid (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire midipkt_pkg::packet_t  push_pkt,
  output logic                       up_ready,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output midipkt_pkg::packet_t       m_pkt
);

  logic                 main_valid;
  midipkt_pkg::packet_t main_pkt;
  logic                 skid_valid;
  midipkt_pkg::packet_t skid_pkt;
  logic                 main_free;

  assign up_ready  = !skid_valid;
  assign main_free = !main_valid || m_tready;

  // Control: refill main from skid first, else from upstream
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push && up_ready) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: move data alongside the control
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_pkt <= skid_valid ? skid_pkt : push_pkt;
    end else if (push && up_ready) begin
      skid_pkt <= push_pkt;
    end
  end

  assign m_tvalid = main_valid;
  assign m_pkt    = main_pkt;

  `ASSERT_IMPLIES(a_skid_behind_main, clk, rst, skid_valid, main_valid, "skid entry held with empty output")

endmodule

`default_nettype wire

// ===== tb/usb_midi_packet_check.sv =====
// ----------------------------------------------------------------------------
// usb_midi_packet_check
// Watches both stream channels of the MIDI byte to USB-MIDI packet converter.
// Every accepted MIDI byte goes through a local copy of the message assembly
// (running status, system common lengths, sysex chunking, real-time
// pass-through). The packets it produces wait in order until the matching
// output transfer arrives, and each field is compared as it arrives.
// ----------------------------------------------------------------------------
module usb_midi_packet_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] midi_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,     // [7:0] first_byte, [15:8] second_byte, [23:16] third_byte
  input  logic [3:0]  m_tuser,     // [3:0] code_index
  output int unsigned mismatch_count,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Message assembly state
  logic [7:0] held_bytes [3];
  logic [1:0] held_count;
  logic [7:0] channel_status;
  logic       sysex_open;

  // Packets predicted but not yet seen on the output
  midipkt_pkg::packet_t awaited_packets [$];

  task automatic clear_held();
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
    held_bytes[2] = 8'h00;
    held_count    = 2'd0;
  endtask

  task automatic hold_byte(input logic [7:0] b);
    held_bytes[held_count % 3] = b;
    held_count = held_count + 2'd1;
  endtask

  // Queue the held bytes as one packet, then empty the message
  task automatic send_held(input logic [3:0] cin);
    midipkt_pkg::packet_t pkt;
    pkt.code_index  = cin;
    pkt.first_byte  = held_bytes[0];
    pkt.second_byte = held_bytes[1];
    pkt.third_byte  = held_bytes[2];
    awaited_packets.push_back(pkt);
    clear_held();
  endtask

  // Advance the assembly by one MIDI byte
  task automatic take_midi_byte(input logic [7:0] b);
    midipkt_pkg::packet_t pkt;
    logic [7:0] lead;
    logic       two_byte;
    logic [1:0] msg_len;
    if (b >= midipkt_pkg::RT_MIN) begin
      // real-time: out at once, assembly untouched
      pkt.code_index  = midipkt_pkg::CIN_SINGLE;
      pkt.first_byte  = b;
      pkt.second_byte = 8'h00;
      pkt.third_byte  = 8'h00;
      awaited_packets.push_back(pkt);
    end else if (b == midipkt_pkg::SYSEX_END && sysex_open) begin
      hold_byte(b);
      sysex_open = 1'b0;
      send_held(midipkt_pkg::CIN_SYSEX + {2'b00, held_count});
    end else if (b[7]) begin
      // any other status starts a new message and ends an open sysex
      clear_held();
      held_bytes[0]  = b;
      held_count     = 2'd1;
      sysex_open     = (b == midipkt_pkg::SYSEX_START);
      channel_status = (b < midipkt_pkg::SYSEX_START) ? b : midipkt_pkg::NO_STATUS;
      if (b == midipkt_pkg::TUNE_REQ) begin
        send_held(midipkt_pkg::CIN_SYS1);
      end
    end else if (sysex_open) begin
      hold_byte(b);
      if (held_count == 2'(midipkt_pkg::MSG_DEPTH)) begin
        send_held(midipkt_pkg::CIN_SYSEX);
      end
    end else if (held_count != 2'd0 || channel_status != midipkt_pkg::NO_STATUS) begin
      // data byte of a message; reuse the running status if none is open
      if (held_count == 2'd0) begin
        held_bytes[0] = channel_status;
        held_count    = 2'd1;
      end
      hold_byte(b);
      lead     = held_bytes[0];
      two_byte = ((lead & midipkt_pkg::TWO_BYTE_MASK) == midipkt_pkg::TWO_BYTE_CHAN) ||
                 lead == midipkt_pkg::SONG_SEL_QF || lead == midipkt_pkg::SONG_SEL;
      msg_len  = two_byte ? 2'd2 : 2'd3;
      if (held_count >= msg_len) begin
        if (lead < midipkt_pkg::SYSEX_START) begin
          send_held(lead[7:4]);
        end else begin
          send_held(two_byte ? midipkt_pkg::CIN_SYS2 : midipkt_pkg::CIN_SYS3);
        end
      end
    end
    // otherwise: data with no status to attach to, drop it
  endtask

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %02h, got %02h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Compare output transfers, then predict from input transfers
  always @(posedge clk) begin : watch
    midipkt_pkg::packet_t want;
    if (rst) begin
      clear_held();
      channel_status = midipkt_pkg::NO_STATUS;
      sysex_open     = 1'b0;
      awaited_packets.delete();
      mismatch_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_packets.size() == 0) begin
          $display("%0t ns: unexpected packet: expected none, got cin %h bytes %06h",
                   $time, m_tuser, m_tdata);
          mismatch_count++;
        end else begin
          want = awaited_packets.pop_front();
          compare_field("code_index", {4'h0, want.code_index}, {4'h0, m_tuser});
          compare_field("first_byte", want.first_byte, m_tdata[7:0]);
          compare_field("second_byte", want.second_byte, m_tdata[15:8]);
          compare_field("third_byte", want.third_byte, m_tdata[23:16]);
        end
      end
      if (s_tvalid && s_tready) begin
        take_midi_byte(s_tdata);
      end
    end
    outstanding <= awaited_packets.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the MIDI byte to USB-MIDI packet converter.
// A short directed byte sequence covers each message kind and the corner
// cases of the assembly; then mostly well-formed random messages with stray
// real-time bytes, truncated messages and noise follow. Both channels idle
// at random, the receiver holds off once for a long stretch, and the sender
// pauses twice until all packets are out. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned TOTAL_BYTES     = 1025;

  // System common statuses without a package name
  localparam logic [7:0] SONG_POS = 8'hF2;
  localparam logic [7:0] UNDEF_F4 = 8'hF4;
  localparam logic [7:0] UNDEF_F5 = 8'hF5;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [3:0]  m_tuser;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;

  bit sender_gaps_on  = 1'b1;
  bit ready_stalls_on = 1'b1;
  bit hold_off_req    = 1'b0;
  bit hold_off_done   = 1'b0;

  // Directed opening: drop without status, note on, running status with a
  // real-time byte in the middle, program change, tune request and the data
  // it orphans, song select, lone end of sysex, sysex chunk and end, and a
  // status that cuts a sysex short
  logic [7:0] opening_bytes [0:25] = '{
    8'h00,
    8'h90, 8'h00, 8'h7F,
    8'h7F, 8'hFF, 8'h00,
    8'hC0, 8'h7F,
    midipkt_pkg::TUNE_REQ, 8'h11,
    midipkt_pkg::SONG_SEL, 8'h05,
    midipkt_pkg::SYSEX_END, 8'h10, 8'h20,
    midipkt_pkg::SYSEX_START, 8'h01, 8'h02, 8'h03, midipkt_pkg::SYSEX_END,
    midipkt_pkg::SYSEX_START, 8'h7F, 8'h90, 8'h40, 8'h40
  };

  midi_bytes_to_usb_midi_packets DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  usb_midi_packet_check packet_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #5 clk = ~clk;

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [7:0] random_realtime();
    return 8'($urandom_range(255, midipkt_pkg::RT_MIN));
  endfunction

  function automatic logic [7:0] random_data();
    return 8'($urandom_range(127, 0));
  endfunction

  // Offer one byte and hold it until the transfer
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sometimes slip a real-time byte in ahead
  task automatic send_midi(input logic [7:0] b);
    if ($urandom_range(15, 0) == 0) begin
      send_byte(random_realtime());
    end
    send_byte(b);
  endtask

  // Stop offering and wait until every predicted packet is out
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_random_message();
    int unsigned kind;
    int unsigned n;
    logic [7:0]  status;
    kind = $urandom_range(99, 0);
    if (kind < 45) begin
      // channel message, often on running status, now and then cut short
      status = 8'($urandom_range(8'hEF, 8'h80));
      n = ((status & midipkt_pkg::TWO_BYTE_MASK) == midipkt_pkg::TWO_BYTE_CHAN) ? 1 : 2;
      if ($urandom_range(3, 0) != 0) send_midi(status);
      if ($urandom_range(19, 0) == 0) n--;
      repeat (n) send_midi(random_data());
    end else if (kind < 60) begin
      // system common
      case ($urandom_range(6, 0))
        0: status = midipkt_pkg::SONG_SEL_QF;
        1: status = midipkt_pkg::SONG_SEL;
        2: status = SONG_POS;
        3: status = UNDEF_F4;
        4: status = UNDEF_F5;
        5: status = midipkt_pkg::TUNE_REQ;
        default: status = midipkt_pkg::SYSEX_END;
      endcase
      if (status == midipkt_pkg::TUNE_REQ) n = 0;
      else if (status == midipkt_pkg::SONG_SEL_QF || status == midipkt_pkg::SONG_SEL) n = 1;
      else n = 2;
      send_midi(status);
      if (n != 0 && $urandom_range(9, 0) == 0) n--;
      repeat (n) send_midi(random_data());
    end else if (kind < 85) begin
      // sysex of random length, mostly closed by its end byte
      send_midi(midipkt_pkg::SYSEX_START);
      repeat ($urandom_range(9, 0)) send_midi(random_data());
      if ($urandom_range(99, 0) < 85) send_midi(midipkt_pkg::SYSEX_END);
      else send_midi(8'($urandom_range(8'hF6, 8'h80)));
    end else if (kind < 92) begin
      send_midi(random_realtime());
    end else begin
      send_midi(8'($urandom_range(255, 0)));
    end
  endtask

  task automatic random_until(input int unsigned count);
    while (bytes_sent < count) send_random_message();
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
        m_tready <= 1'b1;
      end else if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (ready_stalls_on && $urandom_range(3, 0) == 0) begin
        stall_left = pick_gap();
        m_tready <= (stall_left == 0);
        if (stall_left != 0) stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    random_until(300);

    // Long receiver hold-off while the sender keeps pushing real-time bytes
    hold_off_req   = 1'b1;
    sender_gaps_on = 1'b0;
    repeat (40) send_byte(random_realtime());
    sender_gaps_on = 1'b1;

    random_until(450);
    wait_for_drain();

    // Stretch with no idling on either side
    sender_gaps_on  = 1'b0;
    ready_stalls_on = 1'b0;
    random_until(600);
    sender_gaps_on  = 1'b1;
    ready_stalls_on = 1'b1;

    random_until(TOTAL_BYTES);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
